/* hdl/mcstb_pkg.sv */
// Shared types and constants for the multi-channel timer bank.
// No dependencies; imported by the controller, datapath and top level.
package mcstb_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int CFG_IDX_W        = 4;
  localparam int MASK_W           = 8;
  localparam int COUNT_W          = 32;

  // Request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_SET   = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOPWATCH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         channel;
    logic [COUNT_W-1:0] time_value;
    logic               reload_flag;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count_read;
    logic [MASK_W-1:0]  expired_mask;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new item, clear the result (ok set for a tick)
    logic walk;   // apply the tick to the channel under the walk index
    logic exec;   // carry out the captured command
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_tick;
  } dp_status_t;

endpackage

/* hdl/mcstb_ctrl.sv */
// Controller for the timer bank: accepts items, walks channels on a tick or
// executes a command, strobes the result. Depends on mcstb_pkg.
module mcstb_ctrl #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF,
  parameter int IDX_W        = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mcstb_pkg::dp_status_t  status,
  output mcstb_pkg::ctrl_cmd_t   cmd,
  output logic [IDX_W-1:0]       walk_idx,
  output logic                   busy,
  output logic                   result_valid
);
  import mcstb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk index: hold at zero outside a walk, advance one channel a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == ST_WALK) begin
      idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    end else begin
      idx <= '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = status.in_is_tick ? ST_WALK : ST_EXEC;
        end
      end
      ST_WALK: begin
        if (idx == LAST_IDX) begin
          state_next = ST_RESP;
        end
      end
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_WALK: cmd.walk = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      ST_RESP: result_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign walk_idx = idx;

endmodule

/* hdl/mcstb_dp.sv */
// Datapath for the timer bank: channel counts, reloads, running flags,
// configuration masks and the result register. Depends on mcstb_pkg.
module mcstb_dp #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF,
  parameter int IDX_W        = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcstb_pkg::req_t                   req,
  input  mcstb_pkg::ctrl_cmd_t              cmd,
  input  logic [IDX_W-1:0]                  walk_idx,
  input  logic                              cfg_valid,
  input  logic [mcstb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcstb_pkg::MASK_W-1:0]      cfg_data,
  output mcstb_pkg::dp_status_t             status,
  output mcstb_pkg::rsp_t                   result
);
  import mcstb_pkg::*;

  logic [COUNT_W-1:0] count   [NUM_CHANNELS];
  logic [COUNT_W-1:0] reload  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] running;
  logic [MASK_W-1:0]  stopwatch_mask;
  logic [MASK_W-1:0]  notify_mask;
  req_t               cur;

  logic [IDX_W-1:0]   addr;
  logic [3:0]         addr4;
  logic               ch_valid;
  logic               sw_bit;
  logic               nt_bit;
  logic [COUNT_W-1:0] cnt_rd;
  logic [COUNT_W-1:0] rld_rd;
  logic               run_rd;
  logic [COUNT_W-1:0] cnt_dec;

  assign status.in_is_tick = (req.req_type == REQ_TICK);

  // One shared channel port: walk index during a tick, else the command's channel
  assign addr     = cmd.walk ? walk_idx : IDX_W'(cur.channel);
  assign addr4    = 4'(addr);
  assign ch_valid = (5'(cur.channel) < 5'(NUM_CHANNELS));
  assign sw_bit   = !addr4[3] && stopwatch_mask[addr4[2:0]];
  assign nt_bit   = !addr4[3] && notify_mask[addr4[2:0]];
  assign cnt_rd   = count[addr];
  assign rld_rd   = reload[addr];
  assign run_rd   = running[addr];
  assign cnt_dec  = cnt_rd - COUNT_W'(1);

  // Configuration masks
  always_ff @(posedge clk) begin
    if (rst) begin
      stopwatch_mask <= '0;
      notify_mask    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STOPWATCH) begin
        stopwatch_mask <= cfg_data;
      end else if (cfg_index == CFG_NOTIFY) begin
        notify_mask <= cfg_data;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  // Channel state: tick step or command update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count[i]  <= '0;
        reload[i] <= '0;
      end
      running <= '0;
    end else if (cmd.walk) begin
      if (run_rd) begin
        if (sw_bit) begin
          count[addr] <= cnt_rd + COUNT_W'(1);
        end else if (cnt_dec == '0) begin
          if (rld_rd != '0) begin
            count[addr] <= rld_rd;
          end else begin
            count[addr]   <= cnt_dec;
            running[addr] <= 1'b0;
          end
        end else begin
          count[addr] <= cnt_dec;
        end
      end
    end else if (cmd.exec && ch_valid) begin
      case (cur.req_type)
        REQ_SET: begin
          count[addr]  <= cur.time_value;
          reload[addr] <= cur.reload_flag ? cur.time_value : '0;
        end
        REQ_START: begin
          if (!run_rd && (sw_bit || cnt_rd != '0)) begin
            running[addr] <= 1'b1;
          end
        end
        REQ_STOP:  running[addr] <= 1'b0;
        REQ_CLEAR: count[addr] <= '0;
        default:   ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.ok           <= (req.req_type == REQ_TICK);
      result.count_read   <= '0;
      result.expired_mask <= '0;
    end else if (cmd.walk) begin
      if (run_rd && !sw_bit && cnt_dec == '0 && nt_bit) begin
        result.expired_mask[addr4[2:0]] <= 1'b1;
      end
    end else if (cmd.exec && ch_valid) begin
      case (cur.req_type) inside
        REQ_SET, REQ_STOP, REQ_CLEAR: result.ok <= 1'b1;
        REQ_START: result.ok <= run_rd || sw_bit || (cnt_rd != '0);
        REQ_READ: begin
          result.ok         <= 1'b1;
          result.count_read <= cnt_rd;
        end
        default: result.ok <= 1'b0;
      endcase
    end
  end

endmodule

/* hdl/multi_channel_soft_timer_bank.sv */
// Top level of the multi-channel timer bank: controller plus datapath.
// Depends on mcstb_pkg, mcstb_ctrl and mcstb_dp.
//
//   port group   direction  handshake                 payload
//   request      in         start & !busy             req (req_t)
//   result       out        result_valid, one cycle   result (rsp_t)
//   config       in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// After a tick is accepted, the controller walks the channels one per cycle
// through a single shared channel port, then strobes the result. A command
// goes through the execute state instead. Requests are taken only in idle.
// Synchronous reset clears all counts, reloads, running flags and masks.
// The result cannot be stalled; config is always ready.
module multi_channel_soft_timer_bank #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mcstb_pkg::req_t                   req,
  output logic                              result_valid,
  output mcstb_pkg::rsp_t                   result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcstb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcstb_pkg::MASK_W-1:0]      cfg_data
);
  import mcstb_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] walk_idx;

  assign cfg_ready = 1'b1;

  mcstb_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .status      (status),
    .cmd         (cmd),
    .walk_idx    (walk_idx),
    .busy        (busy),
    .result_valid(result_valid)
  );

  mcstb_dp #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .walk_idx (walk_idx),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .status   (status),
    .result   (result)
  );

endmodule
